### sv/daosd_pkg.sv
// ----------------------------------------------------------------------------
// daosd_pkg
// Shared types, constants and width helpers of the door angle detector.
// ----------------------------------------------------------------------------
package daosd_pkg;

	// field widths
	localparam int ANGLE_W     = 13;
	localparam int HALF_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 3;

	// default of the top level parameter
	localparam int AVG_DEPTH_DEF = 4;

	// fraction bits of every angle in the 13 bit angle fields
	localparam int ANGLE_FRAC_BITS = 4;

	// turn sizes in whole degrees
	localparam int HALF_TURN_DEG = 180;
	localparam int FULL_TURN_DEG = 360;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_ANGLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_ANGLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd2;

	// register reset values
	localparam logic [ANGLE_W-1:0] OPEN_ANGLE_RST  = 13'd4640;
	localparam logic [ANGLE_W-1:0] SNAP_ANGLE_RST  = 13'd1760;
	localparam logic [HALF_W-1:0]  HALF_WIDTH_RST  = 8'd48;

	typedef struct packed {
		logic [ANGLE_W-1:0] open_angle;
		logic [ANGLE_W-1:0] snap_angle;
		logic [HALF_W-1:0]  window_half_width;
	} cfg_t;

	typedef struct packed {
		logic               snap_event;
		logic               open_event;
		logic               armed;
		logic [ANGLE_W-1:0] mean_angle;
		logic [ANGLE_W-1:0] folded_angle;
	} result_t;

	// a folded angle is at most the largest heading plus half a turn
	function automatic int ring_width(input int frac_bits);
		return $clog2((2 ** ANGLE_W) + (HALF_TURN_DEG << frac_bits));
	endfunction

	function automatic int sum_width(input int depth, input int frac_bits);
		return ring_width(frac_bits) + $clog2(depth);
	endfunction

endpackage

### sv/daosd_ring.sv
// ----------------------------------------------------------------------------
// daosd_ring
// Input register, tilt fold, averaging ring and running ring sum.
// ----------------------------------------------------------------------------
module daosd_ring import daosd_pkg::*; #(
	parameter int AVG_DEPTH       = AVG_DEPTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [ANGLE_W-1:0]                            heading,
	input  logic                                          tilt_negative,
	output logic                                          dn_valid,
	input  logic                                          dn_ready,
	output logic [ANGLE_W-1:0]                            folded_angle,
	output logic [sum_width(AVG_DEPTH, ANGLE_FRAC_BITS)-1:0] sum
);

	localparam int RING_W = ring_width(ANGLE_FRAC_BITS);
	localparam int SUM_W  = sum_width(AVG_DEPTH, ANGLE_FRAC_BITS);
	localparam int PTR_W  = $clog2(AVG_DEPTH);
	localparam logic [RING_W:0] HALF_TURN = (RING_W + 1)'(HALF_TURN_DEG << ANGLE_FRAC_BITS);
	localparam logic [RING_W:0] FULL_TURN = (RING_W + 1)'(FULL_TURN_DEG << ANGLE_FRAC_BITS);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_DEPTH - 1);

	logic                 v_s1;
	logic [ANGLE_W-1:0]   heading_s1;
	logic                 tilt_s1;
	logic                 v_s2;
	logic [ANGLE_W-1:0]   folded_s2;
	logic [SUM_W-1:0]     sum_s2;

	logic [RING_W-1:0]    ring_q [AVG_DEPTH];
	logic [PTR_W-1:0]     ptr_q;
	logic                 primed_q;

	logic                 s2_free;
	logic                 adv;
	logic [RING_W:0]      plus_half;
	logic [RING_W:0]      wide_folded;
	logic [RING_W-1:0]    folded;
	logic [SUM_W-1:0]     sum_nxt;

	assign s2_free  = !v_s2 || dn_ready;
	assign in_ready = !v_s1 || s2_free;
	assign adv      = v_s1 && s2_free;

	// fold: on negative tilt add half a turn and take one full turn off when past it, else pass the heading
	always_comb begin
		plus_half = (RING_W + 1)'(heading_s1) + HALF_TURN;
		if (!tilt_s1) begin
			wide_folded = (RING_W + 1)'(heading_s1);
		end else if (plus_half > FULL_TURN) begin
			wide_folded = plus_half - FULL_TURN;
		end else begin
			wide_folded = plus_half;
		end
		folded = wide_folded[RING_W-1:0];
	end

	// first item fills the whole ring, later ones replace the oldest entry
	always_comb begin
		if (!primed_q) begin
			sum_nxt = SUM_W'(folded) * SUM_W'(AVG_DEPTH);
		end else begin
			sum_nxt = sum_s2 - SUM_W'(ring_q[ptr_q]) + SUM_W'(folded);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			ptr_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (adv) begin
				primed_q <= 1'b1;
				ptr_q    <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			heading_s1 <= heading;
			tilt_s1    <= tilt_negative;
		end
		if (adv) begin
			folded_s2 <= folded[ANGLE_W-1:0];
			sum_s2    <= sum_nxt;
			for (int i = 0; i < AVG_DEPTH; i++) begin
				if (!primed_q || ptr_q == PTR_W'(i)) begin
					ring_q[i] <= folded;
				end
			end
		end
	end

	assign dn_valid     = v_s2;
	assign folded_angle = folded_s2;
	assign sum          = sum_s2;

	a_primed_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> primed_q)
		else $error("ring not primed after an item");

	a_ptr_zero_unprimed: assert property (@(posedge clk) disable iff (!arst_n)
		!primed_q |-> (ptr_q == '0))
		else $error("ring pointer moved before priming");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && !dn_ready |=> dn_valid && $stable(folded_angle) && $stable(sum))
		else $error("ring item changed while stalled");

endmodule

### sv/daosd_arm.sv
// ----------------------------------------------------------------------------
// daosd_arm
// Mean of the ring sum, open and snap window tests, arm flag, result register.
// ----------------------------------------------------------------------------
module daosd_arm import daosd_pkg::*; #(
	parameter int AVG_DEPTH       = AVG_DEPTH_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             up_valid,
	output logic                                             up_ready,
	input  logic [ANGLE_W-1:0]                               folded_angle,
	input  logic [sum_width(AVG_DEPTH, ANGLE_FRAC_BITS)-1:0] sum,
	input  cfg_t                                             cfg,
	output logic                                             out_valid,
	input  logic                                             out_ready,
	output result_t                                          result
);

	localparam int RING_W  = ring_width(ANGLE_FRAC_BITS);
	localparam int SUM_W   = sum_width(AVG_DEPTH, ANGLE_FRAC_BITS);
	localparam int SHIFT   = SUM_W + $clog2(AVG_DEPTH);
	localparam longint RECIP_L = ((longint'(1) << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
	localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'(RECIP_L);
	localparam int PROD_W  = SUM_W + SHIFT + 1;
	localparam int CMP_W   = ((RING_W > ANGLE_W) ? RING_W : ANGLE_W) + 1;

	logic              out_valid_q;
	logic              armed_q;
	result_t           result_q;

	logic              fire;
	logic [PROD_W-1:0] prod;
	logic [RING_W-1:0] mean;
	logic              open_hit;
	logic              snap_hit;
	logic              open_ev;
	logic              snap_ev;
	logic              armed_mid;
	logic              armed_nxt;

	// strict window, bounds taken without wrap: t - h < v < t + h
	function automatic logic in_window(input logic [RING_W-1:0] value,
			input logic [ANGLE_W-1:0] target, input logic [HALF_W-1:0] half);
		logic [CMP_W-1:0] v;
		logic [CMP_W-1:0] t;
		logic [CMP_W-1:0] h;
		v = CMP_W'(value);
		t = CMP_W'(target);
		h = CMP_W'(half);
		return (v < t + h) && (v + h > t);
	endfunction

	assign up_ready = !out_valid_q || out_ready;
	assign fire     = up_valid && up_ready;

	// divide by the ring depth through a rounded-up reciprocal, exact for every sum
	always_comb begin
		prod      = PROD_W'(sum) * PROD_W'(RECIP);
		mean      = prod[SHIFT +: RING_W];
		open_hit  = in_window(mean, cfg.open_angle, cfg.window_half_width);
		snap_hit  = in_window(mean, cfg.snap_angle, cfg.window_half_width);
		open_ev   = !armed_q && open_hit;
		armed_mid = armed_q || open_ev;
		snap_ev   = armed_mid && snap_hit;
		armed_nxt = armed_mid && !snap_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			armed_q     <= 1'b0;
		end else begin
			if (up_ready) begin
				out_valid_q <= up_valid;
			end
			if (fire) begin
				armed_q <= armed_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.folded_angle <= folded_angle;
			result_q.mean_angle   <= mean[ANGLE_W-1:0];
			result_q.armed        <= armed_nxt;
			result_q.open_event   <= open_ev;
			result_q.snap_event   <= snap_ev;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	a_open_arms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.open_event && !result_q.snap_event |-> result_q.armed)
		else $error("open item left the block disarmed");

	a_snap_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.snap_event |-> !result_q.armed)
		else $error("snap item left the block armed");

	a_no_open_when_armed: assert property (@(posedge clk) disable iff (!arst_n)
		fire && armed_q |=> !result_q.open_event)
		else $error("open item while already armed");

endmodule

### sv/door_angle_open_snap_detector_unit.sv
// ----------------------------------------------------------------------------
// door_angle_open_snap_detector_unit
// Door open and snapshot detector on a stream of heading samples.
// ----------------------------------------------------------------------------
// Each item is a heading in 1/16 degree (tdata) with a tilt-negative flag
// (tuser). The block folds the heading by half a turn on negative tilt, keeps
// a running mean over the last AVG_DEPTH folded angles, arms when the mean
// enters the open window and pulses a snap event when an armed mean enters
// the snap window. One item is taken every cycle while the output is not
// stalled; an accepted item passes through the input register and the ring
// stage into the result register, which drives the output. The rate is set
// by the ring update and the arm flag, each of which feeds its registered
// state back through combinational logic. Configuration registers are
// written through the cfg port, which is always ready.
module door_angle_open_snap_detector_unit import daosd_pkg::*; #(
	parameter int AVG_DEPTH       = AVG_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [12:0] heading
	input  logic                   s_axis_tuser,   // [0] tilt_negative
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [12:0] folded_angle, [25:13] mean_angle
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] armed, [1] open_event, [2] snap_event
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [ANGLE_W-1:0]     cfg_data
);

	localparam int SUM_W = sum_width(AVG_DEPTH, ANGLE_FRAC_BITS);

	cfg_t             cfg_q;
	logic             mid_valid;
	logic             mid_ready;
	logic [ANGLE_W-1:0] mid_folded;
	logic [SUM_W-1:0] mid_sum;
	result_t          result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_angle        <= OPEN_ANGLE_RST;
			cfg_q.snap_angle        <= SNAP_ANGLE_RST;
			cfg_q.window_half_width <= HALF_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OPEN_ANGLE: begin
					cfg_q.open_angle <= cfg_data;
				end
				REG_SNAP_ANGLE: begin
					cfg_q.snap_angle <= cfg_data;
				end
				REG_HALF_WIDTH: begin
					cfg_q.window_half_width <= cfg_data[HALF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	daosd_ring #(
		.AVG_DEPTH       (AVG_DEPTH)
	) u_ring (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.heading       (s_axis_tdata[ANGLE_W-1:0]),
		.tilt_negative (s_axis_tuser),
		.dn_valid      (mid_valid),
		.dn_ready      (mid_ready),
		.folded_angle  (mid_folded),
		.sum           (mid_sum)
	);

	daosd_arm #(
		.AVG_DEPTH       (AVG_DEPTH)
	) u_arm (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (mid_valid),
		.up_ready     (mid_ready),
		.folded_angle (mid_folded),
		.sum          (mid_sum),
		.cfg          (cfg_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.result       (result)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - 2 * ANGLE_W){1'b0}},
		result.mean_angle, result.folded_angle};
	assign m_axis_tuser = {result.snap_event, result.open_event, result.armed};

endmodule
